// ===== src/mpd_pkg.sv =====
// Shared constants and control types for the multiprecision divider.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mpd_pkg;

  // Operand size in bytes (supported range 2 to 8).
  localparam int OPERAND_BYTES = 8;
  localparam int OPERAND_BITS  = OPERAND_BYTES * 8;
  // Width of every operand, quotient and remainder field on the ports.
  localparam int FIELD_WIDTH   = 64;
  localparam int STEP_WIDTH    = $clog2(OPERAND_BITS);
  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(OPERAND_BITS - 1);

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } mpd_cmd_t;

  typedef struct packed {
    logic den_zero;
  } mpd_status_t;

endpackage

// ===== src/mpd_if.sv =====
// Valid/ready channel interfaces for the divider's operand and result transactions.
// Depends on mpd_pkg for the field width.
`timescale 1ns / 1ps

interface mpd_in_if import mpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] dividend_value;
  logic [FIELD_WIDTH-1:0] divisor_value;

  modport source (output valid, output dividend_value, output divisor_value, input ready);
  modport sink   (input valid, input dividend_value, input divisor_value, output ready);
endinterface

interface mpd_out_if import mpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] quotient_value;
  logic [FIELD_WIDTH-1:0] remainder_value;
  logic                   divide_error;

  modport source (output valid, output quotient_value, output remainder_value,
                  output divide_error, input ready);
  modport sink   (input valid, input quotient_value, input remainder_value,
                  input divide_error, output ready);
endinterface

// ===== src/mpd_datapath.sv =====
// Restoring shift-subtract datapath: one quotient bit per step, plus the output register.
// Depends on mpd_pkg for widths and the command/status structs.
`timescale 1ns / 1ps

module mpd_datapath
  import mpd_pkg::*;
(
  input  logic                   clk,
  input  mpd_cmd_t               cmd,
  input  logic [FIELD_WIDTH-1:0] dividend_value,
  input  logic [FIELD_WIDTH-1:0] divisor_value,
  output mpd_status_t            status,
  output logic [FIELD_WIDTH-1:0] quotient_value,
  output logic [FIELD_WIDTH-1:0] remainder_value,
  output logic                   divide_error
);

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  logic [OPERAND_BITS-1:0] quo;
  logic [OPERAND_BITS-1:0] den;
  logic [OPERAND_BITS-1:0] rem;
  logic [OPERAND_BITS:0]   partial;
  logic [OPERAND_BITS+1:0] diff;
  logic                    fits;

  assign partial = {rem, quo[OPERAND_BITS-1]};
  assign diff    = {1'b0, partial} - {2'b00, den};
  assign fits    = ~diff[OPERAND_BITS+1];

  assign status.den_zero = (den == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo <= dividend_value[OPERAND_BITS-1:0];
      den <= divisor_value[OPERAND_BITS-1:0];
      rem <= '0;
    end else if (cmd.step) begin
      quo <= {quo[OPERAND_BITS-2:0], fits};
      rem <= fits ? diff[OPERAND_BITS-1:0] : partial[OPERAND_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      quotient_value  <= status.den_zero ? '0 : FIELD_WIDTH'(quo);
      remainder_value <= status.den_zero ? '0 : FIELD_WIDTH'(rem);
      divide_error    <= status.den_zero;
    end
  end

endmodule

// ===== src/mpd_ctrl.sv =====
// Controller state machine: operand handshake, step counting and result handoff.
// Depends on mpd_pkg for the step counter width and command/status structs.
`timescale 1ns / 1ps

module mpd_ctrl
  import mpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mpd_status_t status,
  output mpd_cmd_t    cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FINISH
  } state_t;

  state_t                state;
  logic [STEP_WIDTH-1:0] count;
  logic                  out_free;

  assign out_free = ~out_valid | out_ready;

  always_comb begin
    cmd.load    = (state == IDLE) & in_valid & in_ready;
    cmd.step    = (state == RUN) & ~status.den_zero;
    cmd.publish = (state == FINISH) & out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_valid && in_ready) begin
            state    <= RUN;
            in_ready <= 1'b0;
            count    <= '0;
          end
        end
        RUN: begin
          // A zero divisor skips the iteration and goes straight to the error result.
          if (status.den_zero || count == LAST_STEP) begin
            state <= FINISH;
          end else begin
            count <= count + STEP_WIDTH'(1);
          end
        end
        FINISH: begin
          if (out_free) begin
            state    <= IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/multiprecision_divider.sv =====
// Top level of the unsigned multiprecision divider.
// Depends on mpd_pkg, mpd_if, mpd_ctrl and mpd_datapath.
//
//   Channel   | Port     | Fields
//   ----------+----------+---------------------------------------------------
//   operands  | sink     | dividend_value[63:0], divisor_value[63:0]
//   results   | source   | quotient_value[63:0], remainder_value[63:0], divide_error
//
// Each item passes through a load, one shift-subtract step per quotient bit and a
// handoff into the output register before the next item is accepted. A zero
// divisor skips the shift-subtract steps.
// Reset is synchronous and clears the controller; no result is pending after it.
// A stalled result holds in the output register while the next item divides; the
// block waits in its handoff cycle only if that register is still occupied.
`timescale 1ns / 1ps

module multiprecision_divider
  import mpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mpd_in_if.sink     operands,
  mpd_out_if.source  results
);

  mpd_cmd_t    cmd;
  mpd_status_t status;

  mpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mpd_datapath u_datapath (
    .clk             (clk),
    .cmd             (cmd),
    .dividend_value  (operands.dividend_value),
    .divisor_value   (operands.divisor_value),
    .status          (status),
    .quotient_value  (results.quotient_value),
    .remainder_value (results.remainder_value),
    .divide_error    (results.divide_error)
  );

  // An error result carries zero quotient and zero remainder.
  assert property (@(posedge clk) disable iff (rst)
    results.valid && results.divide_error |->
      results.quotient_value == '0 && results.remainder_value == '0)
    else $error("divide error result with nonzero payload");

  // Only one division is in flight: acceptance closes the operand channel.
  assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> !operands.ready)
    else $error("operand channel still open after acceptance");

  // The datapath never loads and steps in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step commands overlap");

  // A result is handed off only into a free output register.
  assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !results.valid || results.ready)
    else $error("result overwrote an untaken result");

endmodule
